### hw/rtl/tsr_pkg.sv
// Package for the triangle span rasteriser: shared types and constants.
// Used by the top level and the checker; depends on nothing.
package tsr_pkg;

  // Function codes carried on the func input.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Walk phase of the sequencer.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

endpackage

### hw/rtl/tsr_edge_step.sv
// Shared edge step unit: one Bresenham error add and compare per cycle.
// Depends on nothing; instantiated once by the top level.
module tsr_edge_step #(
  parameter int W = 16
) (
  input  logic signed [W-1:0] err,
  input  logic signed [W-1:0] minor,
  input  logic signed [W-1:0] major,
  input  logic                add_minor,
  output logic signed [W-1:0] err_out,
  output logic                over
);
  logic signed [W-1:0] sum;

  // Add the minor delta when add_minor is set, then take one major delta off if the sum reaches a positive major.
  always_comb begin
    sum  = add_minor ? err + minor : err;
    over = (major > 0) && (sum >= major);
    err_out = over ? sum - major : sum;
  end
endmodule

### hw/rtl/triangle_span_rasterizer_unit.sv
// Top level of the triangle span rasteriser: sort, edge set-up and span walk.
// Depends on tsr_pkg and tsr_edge_step.
//
// channel | direction | handshake      | payload
// in      | input     | valid / ready  | func, vertices, colour
// out     | output    | out_valid/rdy  | span row, left, right, colour, last
//
// A load item is sorted and its edges are set up; a flat top also sets up
// the middle-to-bottom edge. A step item walks the short edge and then the
// long edge of that row through the single shared error unit, up to
// 2^(COORD_BITS+2) moves per edge, then emits the span. Reset clears the
// sequencer to idle. The input waits while a span is held on the output.
module triangle_span_rasterizer_unit
  import tsr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         ready,
  input  logic                         func,
  input  logic signed [COORD_BITS-1:0] vert_a_x,
  input  logic signed [COORD_BITS-1:0] vert_a_y,
  input  logic signed [COORD_BITS-1:0] vert_b_x,
  input  logic signed [COORD_BITS-1:0] vert_b_y,
  input  logic signed [COORD_BITS-1:0] vert_c_x,
  input  logic signed [COORD_BITS-1:0] vert_c_y,
  input  logic [7:0]                   red_in,
  input  logic [7:0]                   green_in,
  input  logic [7:0]                   blue_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] span_row,
  output logic signed [COORD_BITS-1:0] span_left,
  output logic signed [COORD_BITS-1:0] span_right,
  output logic [7:0]                   red_out,
  output logic [7:0]                   green_out,
  output logic [7:0]                   blue_out,
  output logic                         last_span
);
  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 1;   // deltas
  localparam int EW = COORD_BITS + 2;   // error terms
  localparam int NW = COORD_BITS + 3;   // move counter, holds the cap
  localparam logic [NW-1:0] CAP = NW'(1) << (COORD_BITS + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_SORT, S_SETUP, S_SEC, S_SHORT, S_LONG, S_FIN, S_OUT
  } state_t;

  state_t state;
  phase_t phase;
  logic signed [CW-1:0] tx, ty, mx, my, bx, by;
  logic signed [CW-1:0] ry, y0;
  logic signed [DW-1:0] sx, lx, lo, hi;
  logic signed [EW-1:0] serr, lerr;
  logic signed [DW-1:0] smaj, smin, lmaj, lmin, sidx;
  logic c1, c2, n1, n2;
  logic signed [1:0] sp, lp;
  logic [NW-1:0] cnt;
  logic [23:0] colour;

  // Shared error unit, fed by the short or the long edge.
  logic use_long;
  logic signed [EW-1:0] u_err, u_min, u_maj, u_out;
  logic u_add, u_over;
  assign use_long = (state == S_LONG);
  assign u_err = use_long ? lerr : serr;
  assign u_min = use_long ? EW'(lmin) : EW'(smin);
  assign u_maj = use_long ? EW'(lmaj) : EW'(smaj);

  tsr_edge_step #(.W(EW)) u_step (
    .err(u_err), .minor(u_min), .major(u_maj), .add_minor(u_add),
    .err_out(u_out), .over(u_over)
  );

  assign ready = (state == S_IDLE) && !out_valid;

  // Edge set-up helpers.
  logic signed [DW-1:0] d1, e1, d2, e2, sd, sdy, ad;
  logic signed [DW-1:0] bd, bdy, abd;
  always_comb begin
    d1 = DW'(mx) - DW'(tx);
    e1 = DW'(my) - DW'(ty);
    d2 = DW'(bx) - DW'(tx);
    e2 = DW'(by) - DW'(ty);
    bd = DW'(bx) - DW'(mx);
    bdy = DW'(by) - DW'(my);
    sd = d1 < 0 ? -d1 : d1;
    ad = d2 < 0 ? -d2 : d2;
    abd = bd < 0 ? -bd : bd;
    sdy = e1;
  end

  logic signed [DW-1:0] sg1, sg2;
  assign sg1 = n1 ? -DW'(1) : DW'(1);
  assign sg2 = n2 ? -DW'(1) : DW'(1);

  // The short walk loops only while moves remain; both phases add the minor delta.
  always_comb begin
    u_add = 1'b1;
  end

  // The next row is kept one bit wider so that the bottom test sees past the bottom row.
  logic signed [DW-1:0] ry1;
  assign ry1 = DW'(ry) + DW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (valid && ready) begin
            if (func == FUNC_LOAD) begin
              // Select-then-swap ordering, first stage.
              colour <= {red_in, green_in, blue_in};
              if (vert_a_y < vert_b_y && vert_a_y < vert_c_y) begin
                tx <= vert_a_x; ty <= vert_a_y;
                if (vert_b_y < vert_c_y) begin
                  mx <= vert_b_x; my <= vert_b_y; bx <= vert_c_x; by <= vert_c_y;
                end else begin
                  mx <= vert_c_x; my <= vert_c_y; bx <= vert_b_x; by <= vert_b_y;
                end
              end else if (vert_b_y < vert_a_y && vert_b_y < vert_c_y) begin
                tx <= vert_b_x; ty <= vert_b_y;
                if (vert_a_y < vert_c_y) begin
                  mx <= vert_a_x; my <= vert_a_y; bx <= vert_c_x; by <= vert_c_y;
                end else begin
                  mx <= vert_c_x; my <= vert_c_y; bx <= vert_a_x; by <= vert_a_y;
                end
              end else begin
                tx <= vert_c_x; ty <= vert_c_y;
                if (vert_a_y < vert_b_y) begin
                  mx <= vert_a_x; my <= vert_a_y; bx <= vert_b_x; by <= vert_b_y;
                end else begin
                  mx <= vert_b_x; my <= vert_b_y; bx <= vert_a_x; by <= vert_a_y;
                end
              end
              state <= S_SORT;
            end else if (phase != PH_IDLE) begin
              lo <= (sx < lx) ? sx : lx;
              hi <= (sx < lx) ? lx : sx;
              y0 <= ry;
              sp <= 2'sd0; lp <= 2'sd0;
              cnt <= '0;
              state <= S_SHORT;
            end
          end
        end
        S_SORT: begin
          // Compare-swap network, done as the three swaps in order.
          begin : swaps
            logic signed [CW-1:0] a_x, a_y, m_x, m_y, b_x, b_y, t_x, t_y;
            a_x = tx; a_y = ty; m_x = mx; m_y = my; b_x = bx; b_y = by;
            if (a_y > m_y) begin
              t_x = a_x; t_y = a_y; a_x = m_x; a_y = m_y; m_x = t_x; m_y = t_y;
            end
            if (a_y > b_y) begin
              t_x = a_x; t_y = a_y; a_x = b_x; a_y = b_y; b_x = t_x; b_y = t_y;
            end
            if (m_y > b_y) begin
              t_x = m_x; t_y = m_y; m_x = b_x; m_y = b_y; b_x = t_x; b_y = t_y;
            end
            tx <= a_x; ty <= a_y; mx <= m_x; my <= m_y; bx <= b_x; by <= b_y;
          end
          state <= S_SETUP;
        end
        S_SETUP: begin
          sx <= DW'(tx); lx <= DW'(tx); ry <= ty;
          n1 <= d1 < 0; n2 <= d2 < 0;
          c1 <= sdy > sd; c2 <= e2 > ad;
          smaj <= (sdy > sd) ? sdy : sd;
          smin <= (sdy > sd) ? sd : sdy;
          lmaj <= (e2 > ad) ? e2 : ad;
          lmin <= (e2 > ad) ? ad : e2;
          lerr <= EW'(((e2 > ad) ? e2 : ad) >>> 1);
          serr <= EW'(((sdy > sd) ? sdy : sd) >>> 1);
          sidx <= '0;
          phase <= PH_FIRST;
          state <= (ty == my) ? S_SEC : S_IDLE;
        end
        S_SEC: begin
          // Set up the middle-to-bottom edge.
          n1 <= bd < 0;
          sx <= DW'(mx);
          c1 <= bdy > abd;
          smaj <= (bdy > abd) ? bdy : abd;
          smin <= (bdy > abd) ? abd : bdy;
          serr <= EW'(((bdy > abd) ? bdy : abd) >>> 1);
          sidx <= '0;
          phase <= PH_SECOND;
          state <= (out_valid && !(out_ready)) ? S_OUT : S_IDLE;
        end
        S_SHORT: begin
          // One short edge move per cycle.
          if (cnt >= CAP || sidx >= smaj) begin
            cnt <= '0;
            state <= S_LONG;
          end else begin
            serr <= u_out;
            if (phase == PH_FIRST) begin
              sidx <= sidx + DW'(1);
              if (u_over && !c1) begin
                state <= S_LONG; cnt <= '0;
              end else begin
                if (u_over) sp <= n1 ? -2'sd1 : 2'sd1;
                if (c1) begin
                  state <= S_LONG; cnt <= '0;
                end else begin
                  sx <= sx + sg1; cnt <= cnt + NW'(1);
                end
              end
            end else begin
              if (u_over && c1) sp <= n1 ? -2'sd1 : 2'sd1;
              if ((u_over && !c1) || c1) begin
                state <= S_LONG; cnt <= '0;
              end else begin
                sx <= sx + sg1; cnt <= cnt + NW'(1);
                sidx <= sidx + DW'(1);
              end
            end
          end
        end
        S_LONG: begin
          // One long edge move per cycle.
          if (cnt >= CAP || (phase == PH_SECOND && lx == DW'(bx))) begin
            state <= S_FIN;
          end else begin
            lerr <= u_out;
            if (u_over && c2) lp <= n2 ? -2'sd1 : 2'sd1;
            if (u_over || c2) state <= S_FIN;
            else begin
              lx <= lx + sg2; cnt <= cnt + NW'(1);
            end
          end
        end
        S_FIN: begin
          // Close the row, advance both edges and emit the span.
          begin : fin
            logic signed [DW-1:0] l, h, nsx, nlx;
            logic lst;
            logic signed [DW-1:0] ni;
            l = lo; h = hi;
            if (l > sx) l = sx;
            if (l > lx) l = lx;
            if (h < sx) h = sx;
            if (h < lx) h = lx;
            nsx = sx + (c1 ? DW'(0) : sg1) + DW'(sp);
            nlx = lx + (c2 ? DW'(0) : sg2) + DW'(lp);
            lst = 1'b0;
            ni = sidx + DW'(1);
            span_row <= y0; span_left <= CW'(l); span_right <= CW'(h);
            red_out <= colour[23:16]; green_out <= colour[15:8];
            blue_out <= colour[7:0];
            sx <= nsx; lx <= nlx; ry <= CW'(ry1);
            if (phase == PH_FIRST) begin
              if (ry1 == DW'(my) || !(sidx < smaj)) state <= S_SEC;
              else state <= S_IDLE;
            end else begin
              if (ry1 > DW'(by)) lst = 1'b1;
              else begin
                sidx <= ni;
                if (ni > smaj) lst = 1'b1;
              end
              if (lst) phase <= PH_IDLE;
              state <= S_IDLE;
            end
            last_span <= lst;
            out_valid <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/tsr_checker.sv
// Port-level checker for the triangle span rasteriser, bound to the top level.
// Depends on tsr_pkg.
module tsr_checker
  import tsr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input logic func,
  input logic out_valid,
  input logic out_ready,
  input logic last_span,
  input logic signed [COORD_BITS-1:0] span_left
);
  // A span stays offered until it is taken.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("span withdrawn");
  // A held span keeps its left edge and its last flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(span_left) && $stable(last_span))
    else $error("span changed while stalled");
  // No new item while a span waits.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !ready) else $error("ready while span pending");
  // A load never yields a span on the next edge.
  a_load: assert property (@(posedge clk) disable iff (rst)
    valid && ready && func == FUNC_LOAD |=> !out_valid)
    else $error("span after load");
endmodule

bind triangle_span_rasterizer_unit tsr_checker #(.COORD_BITS(COORD_BITS)) u_chk (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready), .func(func),
  .out_valid(out_valid), .out_ready(out_ready), .last_span(last_span),
  .span_left(span_left)
);
